### sv/ohlc_pkg.sv
// ----------------------------------------------------------------------------
// ohlc_pkg
// shared widths, reset values and state types of the bar aggregator
// ----------------------------------------------------------------------------
package ohlc_pkg;

  localparam int unsigned PRICE_W      = 32;
  localparam int unsigned TIME_W       = 48;
  localparam int unsigned IVAL_W       = 32;
  localparam int unsigned OUT_IDX_W    = 12;
  localparam int unsigned NUM_BARS_DEF = 4096;
  localparam int unsigned DIV_STEPS    = TIME_W;
  localparam int unsigned STEP_W       = $clog2(DIV_STEPS);

  localparam logic [IVAL_W-1:0] INTERVAL_RST = 32'd1800000;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_UPD
  } back_state_e;

  // status from the back part to the front part
  typedef struct packed {
    logic clear_done;
  } back_status_t;

endpackage

### sv/ohlc_fifo.sv
// ----------------------------------------------------------------------------
// ohlc_fifo
// two-entry queue between the front and back parts
// ----------------------------------------------------------------------------
module ohlc_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = slot_q[rptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= wdata_i;
  end

endmodule

### sv/ohlc_front.sv
// ----------------------------------------------------------------------------
// ohlc_front
// takes trades, fixes start time, divides elapsed time by the bar interval
// ----------------------------------------------------------------------------
module ohlc_front #(
  parameter int unsigned NUM_BARS = ohlc_pkg::NUM_BARS_DEF,
  parameter int unsigned IDX_W    = $clog2(NUM_BARS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ohlc_pkg::IVAL_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ohlc_pkg::PRICE_W-1:0] price_i,
  input  logic [ohlc_pkg::TIME_W-1:0]  trade_time_i,
  input  ohlc_pkg::back_status_t       status_i,
  output logic                         push_o,
  output logic [ohlc_pkg::PRICE_W+IDX_W:0] entry_o,
  input  logic                         full_i
);
  import ohlc_pkg::*;

  front_state_e        state_q, state_d;
  logic [IVAL_W-1:0]   interval_q;
  logic                started_q;
  logic [TIME_W-1:0]   start_q;
  logic [TIME_W-1:0]   dvd_q, dvd_d;
  logic [IVAL_W-1:0]   rem_q, rem_d;
  logic [IVAL_W-1:0]   div_q, div_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [PRICE_W-1:0]  price_q;
  logic                oor_q, oor_d;
  logic [TIME_W-1:0]   eff_start;
  logic [IVAL_W:0]     shifted;
  logic                qbit;
  logic                accept;
  logic                too_far;

  assign accept     = in_valid_i && in_ready_o;
  assign eff_start  = started_q ? start_q : trade_time_i;
  assign shifted    = {rem_q, dvd_q[TIME_W-1]};
  assign qbit       = (shifted >= {1'b0, div_q});
  assign too_far    = !oor_q && (dvd_q >= TIME_W'(NUM_BARS));
  assign push_o     = (state_q == F_PUSH) && !too_far && !full_i;
  assign entry_o    = {oor_q, dvd_q[IDX_W-1:0], price_q};

  // state, configuration and start time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      interval_q <= INTERVAL_RST;
      started_q  <= 1'b0;
      start_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) interval_q <= cfg_wdata_i;
      if (accept && !started_q) begin
        started_q <= 1'b1;
        start_q   <= trade_time_i;
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    step_q <= step_d;
    oor_q  <= oor_d;
    if (accept) price_q <= price_i;
  end

  // next state, one quotient bit per cycle
  always_comb begin
    state_d    = state_q;
    dvd_d      = dvd_q;
    rem_d      = rem_q;
    div_d      = div_q;
    step_d     = step_q;
    oor_d      = oor_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        in_ready_o = status_i.clear_done;
        if (in_valid_i && status_i.clear_done) begin
          dvd_d  = trade_time_i - eff_start;
          rem_d  = '0;
          div_d  = (interval_q == '0) ? IVAL_W'(1) : interval_q;
          step_d = '0;
          if (trade_time_i < eff_start) begin
            oor_d   = 1'b1;
            dvd_d   = '0;
            state_d = F_PUSH;
          end else begin
            oor_d   = 1'b0;
            state_d = F_DIV;
          end
        end
      end
      F_DIV: begin
        rem_d  = qbit ? IVAL_W'(shifted - {1'b0, div_q}) : shifted[IVAL_W-1:0];
        dvd_d  = {dvd_q[TIME_W-2:0], qbit};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (too_far) begin
          oor_d = 1'b1;
          dvd_d = '0;
        end else if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

endmodule

### sv/ohlc_back.sv
// ----------------------------------------------------------------------------
// ohlc_back
// bar store read-modify-write, highest bar tracking and result register
// ----------------------------------------------------------------------------
module ohlc_back #(
  parameter int unsigned NUM_BARS = ohlc_pkg::NUM_BARS_DEF,
  parameter int unsigned IDX_W    = $clog2(NUM_BARS)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  logic [ohlc_pkg::PRICE_W+IDX_W:0] entry_i,
  output logic                           pop_o,
  output ohlc_pkg::back_status_t         status_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ohlc_pkg::OUT_IDX_W-1:0] bucket_o,
  output logic [ohlc_pkg::PRICE_W-1:0]   bar_open_o,
  output logic [ohlc_pkg::PRICE_W-1:0]   bar_high_o,
  output logic [ohlc_pkg::PRICE_W-1:0]   bar_low_o,
  output logic [ohlc_pkg::PRICE_W-1:0]   bar_close_o,
  output logic [ohlc_pkg::OUT_IDX_W-1:0] highest_bucket_o,
  output logic                           out_of_range_o
);
  import ohlc_pkg::*;

  // valid mark, open, high, low; the close is always the latest price
  localparam int unsigned ENT_W = 3 * PRICE_W + 1;

  logic [ENT_W-1:0]     mem [NUM_BARS];
  logic [ENT_W-1:0]     rdata_q;
  back_state_e          state_q, state_d;
  logic [IDX_W-1:0]     clr_q;
  logic [PRICE_W-1:0]   price_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 oor_q;
  logic [OUT_IDX_W-1:0] max_q, max_d;
  logic                 out_valid_q;
  logic [OUT_IDX_W-1:0] bucket_q, highest_q;
  logic [PRICE_W-1:0]   open_q, high_q, low_q, close_q;
  logic                 oorr_q;
  logic                 load;
  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic [ENT_W-1:0]     wdata;
  logic                 hit;
  logic [PRICE_W-1:0]   old_open, old_high, old_low;
  logic [PRICE_W-1:0]   new_open, new_high, new_low;
  logic [OUT_IDX_W-1:0] idx12;

  assign pop_o               = (state_q == B_IDLE) && !empty_i;
  assign status_o.clear_done = (state_q != B_CLEAR);
  assign load = (state_q == B_UPD) && (!out_valid_q || out_ready_i);

  // merge trade into candle
  assign hit      = rdata_q[ENT_W-1];
  assign old_open = rdata_q[3*PRICE_W-1:2*PRICE_W];
  assign old_high = rdata_q[2*PRICE_W-1:PRICE_W];
  assign old_low  = rdata_q[PRICE_W-1:0];
  assign new_open = hit ? old_open : price_q;
  assign new_high = (hit && old_high > price_q) ? old_high : price_q;
  assign new_low  = (hit && old_low < price_q) ? old_low : price_q;
  assign idx12    = OUT_IDX_W'(idx_q);
  assign max_d    = (!oor_q && idx12 > max_q) ? idx12 : max_q;

  // store write port, shared with the clearing pass
  assign we    = (state_q == B_CLEAR) || (load && !oor_q);
  assign waddr = (state_q == B_CLEAR) ? clr_q : idx_q;
  assign wdata = (state_q == B_CLEAR) ? '0 : {1'b1, new_open, new_high, new_low};

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (state_q == B_READ) rdata_q <= mem[idx_q];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) clr_q <= clr_q + IDX_W'(1);
      if (load) begin
        max_q       <= max_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      price_q <= entry_i[PRICE_W-1:0];
      idx_q   <= entry_i[PRICE_W+IDX_W-1:PRICE_W];
      oor_q   <= entry_i[PRICE_W+IDX_W];
    end
    if (load) begin
      bucket_q  <= oor_q ? '0 : idx12;
      open_q    <= oor_q ? '0 : new_open;
      high_q    <= oor_q ? '0 : new_high;
      low_q     <= oor_q ? '0 : new_low;
      close_q   <= oor_q ? '0 : price_q;
      highest_q <= max_d;
      oorr_q    <= oor_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_CLEAR: if (clr_q == IDX_W'(NUM_BARS - 1)) state_d = B_IDLE;
      B_IDLE:  if (!empty_i) state_d = B_READ;
      B_READ:  state_d = B_UPD;
      B_UPD:   if (load) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign bucket_o         = bucket_q;
  assign bar_open_o       = open_q;
  assign bar_high_o       = high_q;
  assign bar_low_o        = low_q;
  assign bar_close_o      = close_q;
  assign highest_bucket_o = highest_q;
  assign out_of_range_o   = oorr_q;

endmodule

### sv/ohlc_bar_aggregator.sv
// ----------------------------------------------------------------------------
// ohlc_bar_aggregator
// builds open/high/low/close candles per time bar from a trade stream
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  trade in | in_valid_i / in_ready_o | price_i, trade_time_i
//  candle   | out_valid_o/out_ready_i | bucket_o .. out_of_range_o
//  config   | cfg_we_i                | cfg_wdata_i (bar interval, ms)
//
// an in-range trade shows its candle after 48 steps of the bit-serial divider,
// the push into the queue, then pop, store read and update in the back part.
// the front takes no new trade until it has pushed the last one. a trade
// before the start skips the divider; one past the store is marked out of
// range in the push state before the push. after reset a clearing pass
// walks the whole bar store with in_ready_o low. a stalled output holds the
// back part; the two-entry queue lets the front part keep dividing meanwhile.
module ohlc_bar_aggregator #(
  parameter int unsigned NUM_BARS = ohlc_pkg::NUM_BARS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ohlc_pkg::IVAL_W-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ohlc_pkg::PRICE_W-1:0]   price_i,
  input  logic [ohlc_pkg::TIME_W-1:0]    trade_time_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ohlc_pkg::OUT_IDX_W-1:0] bucket_o,
  output logic [ohlc_pkg::PRICE_W-1:0]   bar_open_o,
  output logic [ohlc_pkg::PRICE_W-1:0]   bar_high_o,
  output logic [ohlc_pkg::PRICE_W-1:0]   bar_low_o,
  output logic [ohlc_pkg::PRICE_W-1:0]   bar_close_o,
  output logic [ohlc_pkg::OUT_IDX_W-1:0] highest_bucket_o,
  output logic                           out_of_range_o
);
  import ohlc_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_BARS);
  localparam int unsigned QW    = PRICE_W + IDX_W + 1;

  logic            push, pop, full, empty;
  logic [QW-1:0]   q_wdata, q_rdata;
  back_status_t    status;

  ohlc_front #(.NUM_BARS(NUM_BARS), .IDX_W(IDX_W)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .price_i, .trade_time_i,
    .status_i(status), .push_o(push), .entry_o(q_wdata), .full_i(full)
  );

  ohlc_fifo #(.WIDTH(QW)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(q_wdata), .full_o(full),
    .pop_i(pop), .rdata_o(q_rdata), .empty_o(empty)
  );

  ohlc_back #(.NUM_BARS(NUM_BARS), .IDX_W(IDX_W)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .entry_i(q_rdata), .pop_o(pop),
    .status_o(status), .out_valid_o, .out_ready_i, .bucket_o, .bar_open_o,
    .bar_high_o, .bar_low_o, .bar_close_o, .highest_bucket_o, .out_of_range_o
  );

  // rejected trades carry an empty candle
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> bar_open_o == '0 && bar_close_o == '0)
    else $error("rejected trade with nonzero candle");

  // candle extremes are ordered
  a_low_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_of_range_o |-> bar_low_o <= bar_high_o &&
      bar_low_o <= bar_close_o && bar_close_o <= bar_high_o)
    else $error("candle low above high");

  // highest bar covers the current one
  a_highest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_of_range_o |-> highest_bucket_o >= bucket_o)
    else $error("highest bar below current bar");

  // no trade is taken during the clearing pass
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !status.clear_done |-> !in_ready_o)
    else $error("trade accepted while clearing");

endmodule

### tb/sv/ohlc_bar_aggregator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohlc_bar_aggregator_tb
// drives trade words into the bar aggregator under several bar intervals,
// keeps its own candle store to predict each candle word, and compares
// every candle word field by field in arrival order
// ----------------------------------------------------------------------------
module ohlc_bar_aggregator_tb;
  import ohlc_pkg::*;

  localparam int unsigned NBARS      = 4096;
  localparam int unsigned WDOG_LIMIT = 40000;
  localparam int unsigned LONG_HOLD  = 400;
  localparam logic [TIME_W-1:0] T_START = 48'h0000_0100_0000;

  typedef enum logic [1:0] {
    TR_IN_BAR,
    TR_BEFORE_START,
    TR_PAST_STORE
  } trade_kind_e;

  typedef struct {
    logic [PRICE_W-1:0] price;
    logic [TIME_W-1:0]  ttime;
  } trade_t;

  typedef struct {
    logic [OUT_IDX_W-1:0] bucket;
    logic [PRICE_W-1:0]   open;
    logic [PRICE_W-1:0]   high;
    logic [PRICE_W-1:0]   low;
    logic [PRICE_W-1:0]   close;
    logic [OUT_IDX_W-1:0] highest;
    logic                 oor;
  } candle_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [IVAL_W-1:0]    cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [PRICE_W-1:0]   price_i = '0;
  logic [TIME_W-1:0]    trade_time_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [OUT_IDX_W-1:0] bucket_o;
  logic [PRICE_W-1:0]   bar_open_o;
  logic [PRICE_W-1:0]   bar_high_o;
  logic [PRICE_W-1:0]   bar_low_o;
  logic [PRICE_W-1:0]   bar_close_o;
  logic [OUT_IDX_W-1:0] highest_bucket_o;
  logic                 out_of_range_o;

  ohlc_bar_aggregator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .price_i          (price_i),
    .trade_time_i     (trade_time_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .bucket_o         (bucket_o),
    .bar_open_o       (bar_open_o),
    .bar_high_o       (bar_high_o),
    .bar_low_o        (bar_low_o),
    .bar_close_o      (bar_close_o),
    .highest_bucket_o (highest_bucket_o),
    .out_of_range_o   (out_of_range_o)
  );

  always #2 clk_i = ~clk_i;

  // shadow state of the aggregator
  logic [IVAL_W-1:0]    interval_ms = INTERVAL_RST;
  logic                 seen_first = 1'b0;
  logic [TIME_W-1:0]    first_time = '0;
  logic [OUT_IDX_W-1:0] top_bucket = '0;
  logic                 bar_seen [NBARS];
  candle_t              bar_book [NBARS];

  trade_t  trade_q [$];
  candle_t candle_q [$];
  int      errors = 0;
  int      mism = 0;
  bit      quiet = 1'b0;
  bit      long_hold_req = 1'b0;

  // update the shadow store with one trade and return the candle it yields
  function automatic candle_t fold_trade(logic [PRICE_W-1:0] p, logic [TIME_W-1:0] t);
    candle_t     c;
    logic [63:0] dv;
    logic [63:0] idx;
    c = '{default: '0};
    if (!seen_first) begin
      first_time = t;
      seen_first = 1'b1;
    end
    dv = (interval_ms == 0) ? 64'd1 : 64'(interval_ms);
    idx = (t >= first_time) ? (64'(t) - 64'(first_time)) / dv : 64'd0;
    if (t < first_time || idx >= NBARS) begin
      c.highest = top_bucket;
      c.oor = 1'b1;
      return c;
    end
    if (!bar_seen[idx]) begin
      bar_book[idx].open = p;
      bar_book[idx].high = p;
      bar_book[idx].low = p;
      bar_seen[idx] = 1'b1;
    end else begin
      if (p > bar_book[idx].high) bar_book[idx].high = p;
      if (p < bar_book[idx].low) bar_book[idx].low = p;
    end
    bar_book[idx].close = p;
    if (idx[OUT_IDX_W-1:0] > top_bucket) top_bucket = idx[OUT_IDX_W-1:0];
    c = bar_book[idx];
    c.bucket = idx[OUT_IDX_W-1:0];
    c.highest = top_bucket;
    c.oor = 1'b0;
    return c;
  endfunction

  // random trade, mostly inside the store with many repeats per bar
  function automatic trade_t rand_trade();
    trade_t      tr;
    trade_kind_e kind;
    logic [63:0] dv;
    logic [63:0] b;
    logic [63:0] t;
    int          r;
    dv = (interval_ms == 0) ? 64'd1 : 64'(interval_ms);
    r = $urandom_range(0, 99);
    kind = (r < 80) ? TR_IN_BAR : (r < 90) ? TR_BEFORE_START : TR_PAST_STORE;
    case ($urandom_range(0, 9))
      0: tr.price = '0;
      1: tr.price = '1;
      default: tr.price = $urandom;
    endcase
    case (kind)
      TR_IN_BAR: begin
        b = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 31) : $urandom_range(0, NBARS-1);
        t = 64'(T_START) + b * dv + ({$urandom, $urandom} % dv);
      end
      TR_BEFORE_START: begin
        t = {$urandom, $urandom} % 64'(T_START);
      end
      default: begin
        if ($urandom_range(0, 1)) t = {$urandom, $urandom};
        else t = 64'(T_START) + (64'(NBARS) + $urandom_range(0, 15)) * dv;
      end
    endcase
    tr.ttime = t[TIME_W-1:0];
    return tr;
  endfunction

  // sender: one trade word at a time, random idle bursts
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    trade_t tr;
    bit     took;
    if (rst_ni) begin
      took = in_valid_i && in_ready_o;
      if (took) candle_q.insert(candle_q.size(), fold_trade(price_i, trade_time_i));
      if (in_valid_i && !took) begin
        in_valid_i <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (trade_q.size() != 0 && !quiet && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(1, 7);
        in_valid_i <= 1'b0;
      end else if (trade_q.size() != 0) begin
        tr = trade_q.pop_front();
        price_i <= tr.price;
        trade_time_i <= tr.ttime;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: compare each candle word, random stalls and one long hold-off
  int unsigned stall = 0;
  always @(posedge clk_i) begin
    candle_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (candle_q.size() == 0) begin
          errors++;
          if (mism++ < 10) $display("unexpected candle word, bucket %0d", bucket_o);
        end else begin
          e = candle_q.pop_front();
          if (bucket_o !== e.bucket || bar_open_o !== e.open || bar_high_o !== e.high ||
              bar_low_o !== e.low || bar_close_o !== e.close ||
              highest_bucket_o !== e.highest || out_of_range_o !== e.oor) begin
            errors++;
            if (mism++ < 10) begin
              $display("exp bkt %0d o %h h %h l %h c %h top %0d oor %b", e.bucket, e.open,
                       e.high, e.low, e.close, e.highest, e.oor);
              $display("got bkt %0d o %h h %h l %h c %h top %0d oor %b", bucket_o,
                       bar_open_o, bar_high_o, bar_low_o, bar_close_o, highest_bucket_o,
                       out_of_range_o);
            end
          end
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else if (stall > 0) begin
        stall = stall - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 7);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic set_interval(logic [IVAL_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    interval_ms = v;
  endtask

  task automatic add_trade(logic [PRICE_W-1:0] p, logic [TIME_W-1:0] t);
    trade_t tr;
    tr.price = p;
    tr.ttime = t;
    trade_q.insert(trade_q.size(), tr);
  endtask

  task automatic add_random(int n);
    repeat (n) trade_q.insert(trade_q.size(), rand_trade());
  endtask

  task automatic drain();
    while (trade_q.size() != 0 || in_valid_i || candle_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < NBARS; i++) bar_seen[i] = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: first trade, price extremes, store edges, rejected trades
    set_interval(32'd1);
    add_trade(32'h8000_0000, T_START);
    add_trade(32'hFFFF_FFFF, T_START);
    add_trade(32'h0000_0000, T_START);
    add_trade(32'h1234_5678, T_START);
    add_trade(32'h5555_AAAA, T_START + 48'd4095);
    add_trade(32'hAAAA_5555, T_START + 48'd4095);
    add_trade(32'h0000_0001, T_START + 48'd4096);
    add_trade(32'h0000_0002, T_START - 48'd1);
    add_trade(32'h0000_0003, 48'd0);
    add_trade(32'hFFFF_FFFE, 48'hFFFF_FFFF_FFFF);
    add_trade(32'h0000_0010, T_START + 48'd1);
    add_trade(32'h0000_0020, T_START + 48'd1);
    add_trade(32'h0000_0008, T_START + 48'd1);
    add_trade(32'h7FFF_FFFF, T_START + 48'd2048);
    add_random(240);
    drain();

    // zero interval acts as one
    set_interval(32'd0);
    add_random(200);
    drain();

    // widest interval, long output hold-off fills the block
    set_interval(32'hFFFF_FFFF);
    long_hold_req = 1'b1;
    add_random(350);
    drain();

    set_interval(INTERVAL_RST);
    add_random(350);
    drain();

    // last stretch, its second half with no idling
    set_interval(32'd1000);
    add_random(200);
    drain();
    quiet = 1'b1;
    add_random(200);
    drain();

    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### filelist.f
sv/ohlc_pkg.sv
sv/ohlc_fifo.sv
sv/ohlc_front.sv
sv/ohlc_back.sv
sv/ohlc_bar_aggregator.sv
tb/sv/ohlc_bar_aggregator_tb.sv
